// ----- hdl/htbp_pkg.sv -----
// Shared types and constants for the template bit packer.
// Depends on nothing; imported by htbp_pack, htbp_unpack and the top level.
`timescale 1ns / 1ps
`default_nettype none

package htbp_pkg;

	localparam int unsigned FIELD_MAX_BITS = 64;
	localparam int unsigned FW_W           = $clog2(FIELD_MAX_BITS + 1);
	localparam int unsigned BUCKET_W       = 7;
	localparam int unsigned FILL_W         = 3;
	localparam int unsigned STREAM_MAX     = BUCKET_W + FIELD_MAX_BITS + 8;
	localparam int unsigned MAX_BYTES      = STREAM_MAX / 8;
	localparam int unsigned BUF_W          = MAX_BYTES * 8;
	localparam int unsigned COMB_W         = BUF_W + 8;
	localparam int unsigned LEN_W          = $clog2(COMB_W + 1);
	localparam int unsigned CNT_W          = $clog2(MAX_BYTES + 1);

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_HEX   = 2'd1,
		MODE_WIDTH = 2'd2
	} mode_t;

	// One accepted character's worth of output, right-justified bit stream.
	typedef struct packed {
		logic              valid;
		logic [COMB_W-1:0] bits;
		logic [LEN_W-1:0]  len;
		logic [CNT_W-1:0]  nres;
		logic              rend;
		logic              bvalid;
	} pkt_t;

endpackage

`default_nettype wire

// ----- hdl/htbp_pack.sv -----
// Character decoder, field/bucket state and the stage-1 packet register.
// Depends on htbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htbp_pack
	import htbp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_char,
	input  wire logic       end_of_input,
	output pkt_t            pkt,
	input  wire logic       take
);

	logic                      esc_q;
	mode_t                     mode_q;
	logic                      com_q;
	logic [FIELD_MAX_BITS-1:0] val_q;
	logic [FW_W-1:0]           wid_q;
	logic [BUCKET_W-1:0]       bkt_q;
	logic [FILL_W-1:0]         fill_q;
	logic                      rhb_q;
	pkt_t                      pkt_s1;

	logic                      nx_esc;
	mode_t                     nx_mode;
	logic                      nx_com;
	logic [FIELD_MAX_BITS-1:0] nx_val;
	logic [FW_W-1:0]           nx_wid;
	logic                      emit;
	logic                      lit;
	logic                      nib;
	logic                      do_close;
	logic                      wclr;
	logic [7:0]                litv;
	logic [3:0]                dig;
	logic [FW_W+3:0]           wacc;
	logic [FW_W:0]             wsum;
	logic [FIELD_MAX_BITS-1:0] fv_m;
	logic [FIELD_MAX_BITS+7:0] fl;
	logic [LEN_W-1:0]          lr;
	logic [LEN_W-1:0]          len;
	logic [LEN_W:0]            len_up;
	logic [COMB_W-1:0]         comb;
	logic [CNT_W-1:0]          nbytes;
	logic                      any;
	logic                      marker;
	logic [FILL_W-1:0]         rem;
	logic [BUCKET_W-1:0]       nb;
	logic                      accept;

	assign in_ready = !pkt_s1.valid || take;
	assign accept   = in_valid && in_ready;
	assign pkt      = pkt_s1;
	assign dig      = in_char[6] ? (in_char[3:0] + 4'd9) : in_char[3:0];

	always_comb begin
		nx_esc   = esc_q;
		nx_mode  = mode_q;
		nx_com   = com_q;
		emit     = 1'b0;
		lit      = 1'b0;
		nib      = 1'b0;
		do_close = 1'b0;
		wclr     = 1'b0;
		litv     = in_char;
		if (end_of_input) begin
			do_close = 1'b1;
			emit     = 1'b1;
			nx_esc   = 1'b0;
			nx_mode  = MODE_NONE;
			nx_com   = 1'b0;
		end else begin
			case (in_char) inside
				CH_HASH: begin
					if (esc_q) lit = 1'b1;
					else begin
						nx_com  = 1'b1;
						nx_mode = MODE_NONE;
					end
				end
				CH_BSLASH: begin
					if (esc_q) lit = 1'b1;
					else if (!com_q) begin
						nx_esc  = 1'b1;
						nx_mode = MODE_NONE;
					end
				end
				CH_SPACE, CH_TAB, CH_CR: begin
					if (esc_q) lit = 1'b1;
					else nx_mode = MODE_NONE;
				end
				CH_LF: begin
					if (esc_q) lit = 1'b1;
					else begin
						nx_com   = 1'b0;
						nx_mode  = MODE_NONE;
						do_close = 1'b1;
						emit     = 1'b1;
					end
				end
				CH_N, CH_R, CH_T: begin
					if (esc_q) begin
						lit  = 1'b1;
						litv = (in_char == CH_N) ? CH_LF : ((in_char == CH_R) ? CH_CR : CH_TAB);
					end else if (!com_q) lit = 1'b1;
				end
				[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: begin
					if (!com_q) begin
						if (!esc_q && mode_q == MODE_NONE) lit = 1'b1;
						else nib = 1'b1;
					end
				end
				CH_COLON: begin
					if (!com_q) begin
						if (mode_q == MODE_NONE) lit = 1'b1;
						else begin
							nx_mode = MODE_WIDTH;
							wclr    = 1'b1;
						end
					end
				end
				default: begin
					if (!com_q) lit = 1'b1;
				end
			endcase
		end
		if (lit) begin
			emit    = 1'b1;
			nx_esc  = 1'b0;
			nx_mode = MODE_NONE;
		end
		// a new escaped field flushes the pending one
		if (nib && mode_q == MODE_NONE) emit = 1'b1;

		nx_val = val_q;
		nx_wid = wclr ? '0 : wid_q;
		if (emit) begin
			nx_val = '0;
			nx_wid = '0;
		end
		wacc = ({4'b0, wid_q} << 3) + ({4'b0, wid_q} << 1) + (FW_W+4)'(dig);
		wsum = {1'b0, nx_wid} + (FW_W+1)'(4);
		if (nib) begin
			if (mode_q == MODE_WIDTH) begin
				nx_wid = (wacc > (FW_W+4)'(FIELD_MAX_BITS)) ? FW_W'(FIELD_MAX_BITS)
				                                             : wacc[FW_W-1:0];
			end else begin
				nx_val  = {nx_val[FIELD_MAX_BITS-5:0], dig};
				nx_wid  = (wsum > (FW_W+1)'(FIELD_MAX_BITS)) ? FW_W'(FIELD_MAX_BITS)
				                                              : wsum[FW_W-1:0];
				nx_esc  = 1'b0;
				nx_mode = MODE_HEX;
			end
		end

		// bucket bits, then field bits, then literal, MSB first
		fv_m   = val_q & ({FIELD_MAX_BITS{1'b1}} >> (FW_W'(FIELD_MAX_BITS) - wid_q));
		fl     = !emit ? '0 : (lit ? {fv_m, litv} : {8'b0, fv_m});
		lr     = (emit ? LEN_W'(wid_q) : '0) + (lit ? LEN_W'(8) : '0);
		comb   = (COMB_W'(bkt_q) << lr) | COMB_W'(fl);
		len    = LEN_W'(fill_q) + lr;
		len_up = {1'b0, len} + (LEN_W+1)'(7);
		nbytes = do_close ? CNT_W'(len_up >> 3) : CNT_W'(len >> 3);
		any    = nbytes != '0;
		marker = do_close && rhb_q && !any;
		rem    = len[FILL_W-1:0];
		nb     = comb[BUCKET_W-1:0] & ~({BUCKET_W{1'b1}} << rem);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			mode_q <= MODE_NONE;
			com_q  <= 1'b0;
			val_q  <= '0;
			wid_q  <= '0;
			bkt_q  <= '0;
			fill_q <= '0;
			rhb_q  <= 1'b0;
		end else if (accept) begin
			esc_q  <= nx_esc;
			mode_q <= nx_mode;
			com_q  <= nx_com;
			val_q  <= nx_val;
			wid_q  <= nx_wid;
			bkt_q  <= do_close ? '0 : nb;
			fill_q <= do_close ? '0 : rem;
			rhb_q  <= !do_close && (rhb_q || any);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_s1 <= '0;
		end else if (accept && (any || marker)) begin
			pkt_s1.valid  <= 1'b1;
			pkt_s1.bits   <= comb;
			pkt_s1.len    <= len;
			pkt_s1.nres   <= nbytes + CNT_W'(marker);
			pkt_s1.rend   <= do_close;
			pkt_s1.bvalid <= any;
		end else if (take) begin
			pkt_s1.valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/htbp_unpack.sv -----
// Result register: aligns a packet's bit stream and hands out one byte per transaction.
// Depends on htbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htbp_unpack
	import htbp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire pkt_t       pkt,
	output logic            take,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            record_end
);

	logic              valid_q;
	logic [BUF_W-1:0]  buf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rend_q;
	logic              bv_q;
	logic              last;
	logic              done;
	logic [COMB_W-1:0] lj;

	assign last       = cnt_q == CNT_W'(1);
	assign done       = valid_q && out_ready;
	assign take       = pkt.valid && (!valid_q || (out_ready && last));
	assign lj         = pkt.bits << (LEN_W'(COMB_W) - pkt.len);
	assign out_valid  = valid_q;
	assign out_byte   = buf_q[BUF_W-1 -: 8];
	assign byte_valid = bv_q;
	assign record_end = rend_q && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (take) begin
			valid_q <= 1'b1;
			cnt_q   <= pkt.nres;
		end else if (done) begin
			if (last) valid_q <= 1'b0;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q  <= lj[COMB_W-1 -: BUF_W];
			rend_q <= pkt.rend;
			bv_q   <= pkt.bvalid;
		end else if (done) begin
			buf_q <= buf_q << 8;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/hex_template_bit_packer_unit.sv -----
// Template bit packer: one template character in per cycle while in_ready is high, packed bytes out.
// Depends on htbp_pkg, htbp_pack and htbp_unpack.
//
// One character is accepted per cycle while in_ready is high. The decoder, field
// state and bit bucket update in the accepting cycle; the bits a character releases
// go to a stage-1 packet register and then to the result register, from which the
// results are taken. A character yields 0 to 9 results, and the result register
// hands out one per cycle while out_ready is high, so once a character that releases
// N results reaches the result register, the next character that also releases
// results waits in stage 1 and the input stalls until the last of the N is taken
// (a literal with no field pending gives exactly one byte, so such literals stream at one per cycle).
// A newline or end_of_input pads the last byte with zeros and flags it with
// record_end; if a record that already sent bytes closes with nothing left,
// a single result with byte_valid low carries record_end.
`timescale 1ns / 1ps
`default_nettype none

module hex_template_bit_packer_unit
	import htbp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_char,
	input  wire logic       end_of_input,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            record_end
);

	pkt_t pkt;
	logic take;

	htbp_pack u_pack (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_char      (in_char),
		.end_of_input (end_of_input),
		.pkt          (pkt),
		.take         (take)
	);

	htbp_unpack u_unpack (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt),
		.take       (take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.record_end (record_end)
	);

endmodule

`default_nettype wire

// ----- hdl/htbp_checker.sv -----
// Port-level checks for the template bit packer, bound to the top level.
// Depends on hex_template_bit_packer_unit.
`timescale 1ns / 1ps
`default_nettype none

module htbp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] in_char,
	input wire logic       end_of_input,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       byte_valid,
	input wire logic       record_end
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_char) && $stable(end_of_input))
		else $error("input transaction changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(byte_valid)
		&& $stable(record_end))
		else $error("stalled result changed");

	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> record_end)
		else $error("empty result without record end");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == 8'h00)
		else $error("empty result carries data");

endmodule

bind hex_template_bit_packer_unit htbp_checker u_htbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.in_char      (in_char),
	.end_of_input (end_of_input),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.byte_valid   (byte_valid),
	.record_end   (record_end)
);

`default_nettype wire

// ----- tb/hex_template_bit_packer_unit_tb.sv -----
// Testbench for hex_template_bit_packer_unit: directed table plus random templates,
// table rows checked against their entries, the rest against a packer model. Depends on htbp_pkg.
`timescale 1ns / 1ps

module hex_template_bit_packer_unit_tb;
	import htbp_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       bval;
		logic       rend;
	} outbyte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
		logic       typed;
		logic       nexp;
		outbyte_t   want;
	} stim_t;

	localparam int IDLE_PCT  = 34;
	localparam int HOLD_AT   = 60;
	localparam int HOLD_LEN  = 80;
	localparam int CALM_LO   = 150;
	localparam int CALM_HI   = 230;
	localparam int N_RANDOM  = 300;
	localparam int DRAIN     = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_char = 8'h00;
	logic       end_of_input = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       record_end;

	hex_template_bit_packer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_char(in_char),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.record_end(record_end)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// packer model state
	logic        esc;
	mode_t       fmode;
	logic        cmt;
	logic [63:0] fval;
	logic [6:0]  fwidth;
	logic [6:0]  bucket;
	int          fill;
	logic        has_bytes;
	outbyte_t    step_res [9];
	int          step_n;

	stim_t    stim_q [$];
	outbyte_t pending_bytes [$];
	int       accepted_cnt = 0;
	int       result_cnt = 0;
	int       record_cnt = 0;
	int       errors = 0;
	int       hold_left = 0;
	logic     hold_done = 1'b0;

	function automatic void put_res(logic [7:0] d, logic v, logic r);
		if (step_n < 9) begin
			step_res[step_n] = '{data: d, bval: v, rend: r};
			step_n++;
		end
	endfunction

	function automatic void push_bit(logic b);
		logic [7:0] acc;
		acc = {bucket, b};
		fill++;
		if (fill >= 8) begin
			put_res(acc, 1'b1, 1'b0);
			has_bytes = 1'b1;
			bucket = '0;
			fill = 0;
		end else begin
			bucket = acc[6:0];
		end
	endfunction

	function automatic void push_bits(logic [63:0] val, int width);
		if (width > FIELD_MAX_BITS)
			width = FIELD_MAX_BITS;
		for (int i = width; i > 0; i--)
			push_bit(val[i-1]);
	endfunction

	function automatic void emit_field();
		push_bits(fval, int'(fwidth));
		fval = '0;
		fwidth = '0;
	endfunction

	function automatic void emit_literal(logic [7:0] ch);
		emit_field();
		push_bits({56'd0, ch}, 8);
		esc = 1'b0;
		fmode = MODE_NONE;
	endfunction

	function automatic void close_record();
		int first;
		first = step_n;
		emit_field();
		while (fill != 0)
			push_bit(1'b0);
		if (has_bytes) begin
			if (step_n > first && step_n > 0)
				step_res[step_n-1].rend = 1'b1;
			else
				put_res(8'h00, 1'b0, 1'b1);
		end
		has_bytes = 1'b0;
	endfunction

	function automatic void take_nibble(logic [3:0] d);
		int w;
		if (fmode == MODE_WIDTH) begin
			w = int'(fwidth) * 10 + int'(d);
			fwidth = (w > FIELD_MAX_BITS) ? FIELD_MAX_BITS[6:0] : w[6:0];
		end else begin
			if (fmode == MODE_NONE)
				emit_field();
			fval = {fval[59:0], d};
			fwidth = fwidth + 7'd4;
			if (fwidth > FIELD_MAX_BITS)
				fwidth = FIELD_MAX_BITS[6:0];
			esc = 1'b0;
			fmode = MODE_HEX;
		end
	endfunction

	// Bytes released by one template character, left in step_res[0 .. step_n-1].
	function automatic void pack_char(logic [7:0] ch, logic eoi);
		logic [7:0] d;
		step_n = 0;
		if (eoi) begin
			close_record();
			esc = 1'b0;
			fmode = MODE_NONE;
			cmt = 1'b0;
			return;
		end
		if (esc && (ch == CH_HASH || ch == CH_BSLASH || ch == CH_SPACE || ch == CH_TAB ||
				ch == CH_CR || ch == CH_LF)) begin
			emit_literal(ch);
			return;
		end
		case (ch)
			CH_HASH: begin
				cmt = 1'b1;
				fmode = MODE_NONE;
			end
			CH_BSLASH: if (!cmt) begin
				esc = 1'b1;
				fmode = MODE_NONE;
			end
			CH_SPACE, CH_TAB, CH_CR: fmode = MODE_NONE;
			CH_LF: begin
				cmt = 1'b0;
				fmode = MODE_NONE;
				close_record();
			end
			CH_N, CH_R, CH_T: begin
				if (esc)
					emit_literal(ch == CH_N ? CH_LF : (ch == CH_R ? CH_CR : CH_TAB));
				else if (!cmt)
					emit_literal(ch);
			end
			CH_COLON: if (!cmt) begin
				if (fmode == MODE_NONE) begin
					emit_literal(ch);
				end else begin
					fmode = MODE_WIDTH;
					fwidth = '0;
				end
			end
			default: if (!cmt) begin
				if ((ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "F") ||
						(ch >= "a" && ch <= "f")) begin
					if (!esc && fmode == MODE_NONE) begin
						emit_literal(ch);
					end else begin
						if (ch <= "9")
							d = ch - "0";
						else if (ch <= "F")
							d = ch - "A" + 8'd10;
						else
							d = ch - "a" + 8'd10;
						take_nibble(d[3:0]);
					end
				end else begin
					emit_literal(ch);
				end
			end
		endcase
	endfunction

	function automatic void add_row(logic [7:0] ch, logic eoi, logic typed, logic nexp,
			logic [7:0] d, logic v, logic r);
		stim_q.push_back('{ch: ch, eoi: eoi, typed: typed, nexp: nexp,
			want: '{data: d, bval: v, rend: r}});
	endfunction

	function automatic void add_char(logic [7:0] ch);
		add_row(ch, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
	endfunction

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10)
			return 8'("0" + v);
		return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
	endfunction

	function automatic void gen_field();
		int ndig;
		int sel;
		add_char(CH_BSLASH);
		ndig = ($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4);
		repeat (ndig) add_char(hex_char());
		if ($urandom_range(1)) begin
			add_char(CH_COLON);
			sel = $urandom_range(9);
			if (sel == 0) begin
				add_char("6");
				add_char("4");
			end else if (sel == 1) begin
				add_char("9");
				add_char("9");
				add_char("9");
			end else if (sel == 2) begin
				add_char(hex_char());
				add_char(CH_COLON);
				add_char(8'("0" + $urandom_range(9)));
			end else begin
				repeat ($urandom_range(1, 2)) add_char(8'("0" + $urandom_range(9)));
			end
		end
	endfunction

	function automatic void gen_record();
		int sel;
		repeat ($urandom_range(1, 6)) begin
			sel = $urandom_range(99);
			if (sel < 28) begin
				add_char(8'($urandom_range(8'h21, 8'h7e)));
			end else if (sel < 58) begin
				gen_field();
			end else if (sel < 68) begin
				add_char(CH_BSLASH);
				case ($urandom_range(7))
					0: add_char(CH_N);
					1: add_char(CH_R);
					2: add_char(CH_T);
					3: add_char(CH_BSLASH);
					4: add_char(CH_HASH);
					5: add_char(CH_SPACE);
					6: add_char(CH_COLON);
					default: add_char(8'($urandom_range(255)));
				endcase
			end else if (sel < 78) begin
				case ($urandom_range(2))
					0: add_char(CH_SPACE);
					1: add_char(CH_TAB);
					default: add_char(CH_CR);
				endcase
			end else if (sel < 84) begin
				add_char(CH_HASH);
				repeat ($urandom_range(0, 3)) add_char(8'($urandom_range(8'h20, 8'h7e)));
			end else if (sel < 96) begin
				add_char(8'($urandom_range(255)));
			end else begin
				add_row(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
			end
		end
		sel = $urandom_range(99);
		if (sel < 70)
			add_char(CH_LF);
		else if (sel < 95)
			add_row(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
	endfunction

	// scoreboard
	always @(posedge clk) begin
		outbyte_t exp_b;
		stim_t    row;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				result_cnt++;
				if (record_end)
					record_cnt++;
				if (pending_bytes.size() == 0) begin
					$error("unexpected result: out_byte %h byte_valid %b record_end %b",
						out_byte, byte_valid, record_end);
					errors++;
				end else begin
					exp_b = pending_bytes.pop_front();
					if (out_byte !== exp_b.data) begin
						$error("out_byte: expected %h, got %h", exp_b.data, out_byte);
						errors++;
					end
					if (byte_valid !== exp_b.bval) begin
						$error("byte_valid: expected %b, got %b", exp_b.bval, byte_valid);
						errors++;
					end
					if (record_end !== exp_b.rend) begin
						$error("record_end: expected %b, got %b", exp_b.rend, record_end);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				row = stim_q[accepted_cnt];
				pack_char(in_char, end_of_input);
				if (row.typed) begin
					if (row.nexp)
						pending_bytes.push_back(row.want);
				end else begin
					for (int i = 0; i < step_n; i++)
						pending_bytes.push_back(step_res[i]);
				end
				accepted_cnt++;
			end
		end
	end

	// receiver
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && accepted_cnt >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (accepted_cnt >= CALM_LO && accepted_cnt < CALM_HI) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// sender
	initial begin
		int idx;
		int sent;
		esc = 1'b0;
		fmode = MODE_NONE;
		cmt = 1'b0;
		fval = '0;
		fwidth = '0;
		bucket = '0;
		fill = 0;
		has_bytes = 1'b0;

		// directed: literals, record close, escapes, comment, then one field
		add_row("A",       1'b0, 1'b1, 1'b1, 8'h41, 1'b1, 1'b0);
		add_row(8'hFF,     1'b0, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0);
		add_row(8'h00,     1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0);
		add_row(CH_LF,     1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1);
		add_row(CH_LF,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(CH_N,      1'b0, 1'b1, 1'b1, 8'h0A, 1'b1, 1'b0);
		add_row(CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(CH_R,      1'b0, 1'b1, 1'b1, 8'h0D, 1'b1, 1'b0);
		add_row(CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(CH_T,      1'b0, 1'b1, 1'b1, 8'h09, 1'b1, 1'b0);
		add_row(CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(CH_BSLASH, 1'b0, 1'b1, 1'b1, 8'h5C, 1'b1, 1'b0);
		add_row(CH_HASH,   1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row("x",       1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(CH_LF,     1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1);
		// field with saturated width, hex letter in width, then a repeated colon
		add_char(CH_BSLASH);
		add_char("a");
		add_char(CH_COLON);
		add_char("6");
		add_char("4");
		add_char("c");
		add_char(CH_COLON);
		add_char("3");
		add_row(8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		sent = stim_q.size();
		while (stim_q.size() < sent + N_RANDOM)
			gen_record();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idx = 0;
		@(negedge clk);
		while (idx < stim_q.size()) begin
			if ((accepted_cnt >= CALM_LO && accepted_cnt < CALM_HI) ||
					$urandom_range(99) >= IDLE_PCT) begin
				in_valid <= 1'b1;
				in_char <= stim_q[idx].ch;
				end_of_input <= stim_q[idx].eoi;
				sent = accepted_cnt;
				do @(negedge clk); while (accepted_cnt == sent);
				idx++;
			end else begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b0;

		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);

		$display("Fed %0d template characters (escapes, fields, comments, noise, end of input);",
			accepted_cnt);
		$display("checked %0d packed results across %0d closed records.", result_cnt, record_cnt);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
